/* src/tcw_pkg.sv */
// Shared types, codes and constants of the text console writer.
package tcw_pkg;

    localparam int DEFAULT_COLUMNS = 80;
    localparam int DEFAULT_ROWS    = 25;

    localparam int MODE_W      = 2;
    localparam int CHAR_W      = 8;
    localparam int COLOR_W     = 8;
    localparam int CELL_W      = 16;
    localparam int ROW_FIELD_W = 5;
    localparam int COL_FIELD_W = 7;

    localparam logic [MODE_W-1:0] MODE_PUT   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_READ  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

    localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
    localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
    localparam logic [CHAR_W-1:0] CH_BLANK     = 8'h20;

    localparam logic [COLOR_W-1:0] RESET_COLOR = 8'h07;
    localparam logic [CELL_W-1:0]  RESET_CELL  = {RESET_COLOR, CH_BLANK};

    localparam int CMD_DEPTH = 2;

    localparam int OP_W = 3;
    localparam logic [OP_W-1:0] OP_NOP       = 3'd0;
    localparam logic [OP_W-1:0] OP_PUT       = 3'd1;
    localparam logic [OP_W-1:0] OP_NEWLINE   = 3'd2;
    localparam logic [OP_W-1:0] OP_BACKSPACE = 3'd3;
    localparam logic [OP_W-1:0] OP_READ      = 3'd4;
    localparam logic [OP_W-1:0] OP_CLEAR     = 3'd5;

    typedef struct packed {
        logic [MODE_W-1:0]      mode;
        logic [CHAR_W-1:0]      char_code;
        logic [ROW_FIELD_W-1:0] read_row;
        logic [COL_FIELD_W-1:0] read_col;
    } req_t;

    typedef struct packed {
        logic [CELL_W-1:0]      cell_value;
        logic [ROW_FIELD_W-1:0] cursor_row;
        logic [COL_FIELD_W-1:0] cursor_col;
    } rsp_t;

    typedef struct packed {
        logic [OP_W-1:0]        op;
        logic [CHAR_W-1:0]      ch;
        logic [ROW_FIELD_W-1:0] row;
        logic [COL_FIELD_W-1:0] col;
    } cmd_t;

endpackage

/* src/text_console_writer.sv */
// Top level of the text console writer: front end, command sequencer and cell store.
// Text console with a ROWS x COLUMNS grid of 16-bit cells (attribute byte high,
// character byte low) and a cursor. Each request word yields exactly one response
// word carrying the cursor after the step and, for a cell read, the cell. Requests
// enter a two-entry command queue; the sequencer takes one command a cycle while
// it is idle and the one-entry response register is free. A cell read passes
// through the registered store read before its response. A line feed on the
// last row scrolls by advancing a top-row pointer and blanking one row. A
// clear rewrites the whole store. After reset the store is filled with
// blanks in color 7, and while that reset fill runs, full is
// high; color writes are taken at any time. Write the color only while idle.
module text_console_writer #(
    parameter int ROWS    = tcw_pkg::DEFAULT_ROWS,
    parameter int COLUMNS = tcw_pkg::DEFAULT_COLUMNS
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    output logic                        full,
    input  tcw_pkg::req_t               request,
    output logic                        empty,
    input  logic                        pop,
    output tcw_pkg::rsp_t               response,
    input  logic                        cfg_we,
    input  logic [tcw_pkg::COLOR_W-1:0] cfg_data
);
    import tcw_pkg::*;

    localparam int CELLS  = ROWS * COLUMNS;
    localparam int ADDR_W = $clog2(CELLS);

    logic [COLOR_W-1:0] text_color_reg;
    logic               hold;
    logic               cmd_valid;
    logic               cmd_pop;
    cmd_t               cmd;
    logic               ram_we;
    logic [ADDR_W-1:0]  ram_waddr;
    logic [CELL_W-1:0]  ram_wdata;
    logic [ADDR_W-1:0]  ram_raddr;
    logic [CELL_W-1:0]  ram_rdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            text_color_reg <= RESET_COLOR;
        end
        else if (cfg_we)
        begin
            text_color_reg <= cfg_data;
        end
    end

    tcw_front #(
        .ROWS    (ROWS),
        .COLUMNS (COLUMNS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .request   (request),
        .hold      (hold),
        .cmd_valid (cmd_valid),
        .cmd_pop   (cmd_pop),
        .cmd       (cmd)
    );

    tcw_back #(
        .ROWS    (ROWS),
        .COLUMNS (COLUMNS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (cmd_valid),
        .cmd        (cmd),
        .cmd_pop    (cmd_pop),
        .text_color (text_color_reg),
        .init_busy  (hold),
        .ram_we     (ram_we),
        .ram_waddr  (ram_waddr),
        .ram_wdata  (ram_wdata),
        .ram_raddr  (ram_raddr),
        .ram_rdata  (ram_rdata),
        .empty      (empty),
        .pop        (pop),
        .response   (response)
    );

    tcw_ram #(
        .WIDTH (CELL_W),
        .DEPTH (CELLS)
    ) u_cells (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

endmodule

/* src/tcw_ram.sv */
// Generic simple dual-port RAM with one write port and a registered read port.
module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* src/tcw_front.sv */
// Front end: accepts request words, classifies them and queues commands.
module tcw_front #(
    parameter int ROWS    = tcw_pkg::DEFAULT_ROWS,
    parameter int COLUMNS = tcw_pkg::DEFAULT_COLUMNS
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    output logic          full,
    input  tcw_pkg::req_t request,
    input  logic          hold,
    output logic          cmd_valid,
    input  logic          cmd_pop,
    output tcw_pkg::cmd_t cmd
);
    import tcw_pkg::*;

    localparam int PTR_W = $clog2(CMD_DEPTH);
    localparam int CNT_W = $clog2(CMD_DEPTH + 1);

    cmd_t             queue_reg [CMD_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    cmd_t             cmd_in;
    logic             accept;
    logic             in_range;

    assign full      = (count_reg == CNT_W'(CMD_DEPTH)) || hold;
    assign accept    = push && !full;
    assign cmd_valid = (count_reg != '0);
    assign cmd       = queue_reg[rd_ptr_reg];

    assign in_range = (32'(request.read_row) < ROWS) && (32'(request.read_col) < COLUMNS);

    always_comb
    begin
        cmd_in.ch  = request.char_code;
        cmd_in.row = request.read_row;
        cmd_in.col = request.read_col;
        case (request.mode)
            MODE_PUT:
            begin
                if (request.char_code == CH_NEWLINE)
                begin
                    cmd_in.op = OP_NEWLINE;
                end
                else if (request.char_code == CH_BACKSPACE)
                begin
                    cmd_in.op = OP_BACKSPACE;
                end
                else
                begin
                    cmd_in.op = OP_PUT;
                end
            end
            MODE_READ:
            begin
                cmd_in.op = in_range ? OP_READ : OP_NOP;
            end
            MODE_CLEAR:
            begin
                cmd_in.op = OP_CLEAR;
            end
            default:
            begin
                cmd_in.op = OP_NOP;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            queue_reg[wr_ptr_reg] <= cmd_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (accept)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(CMD_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (cmd_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(CMD_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (accept && !cmd_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (!accept && cmd_pop)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

/* src/tcw_back.sv */
// Back end: sequencer that runs commands against the cell store and issues results.
module tcw_back #(
    parameter int ROWS    = tcw_pkg::DEFAULT_ROWS,
    parameter int COLUMNS = tcw_pkg::DEFAULT_COLUMNS,
    localparam int CELLS  = ROWS * COLUMNS,
    localparam int ADDR_W = $clog2(CELLS)
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cmd_valid,
    input  tcw_pkg::cmd_t                cmd,
    output logic                         cmd_pop,
    input  logic [tcw_pkg::COLOR_W-1:0]  text_color,
    output logic                         init_busy,
    output logic                         ram_we,
    output logic [ADDR_W-1:0]            ram_waddr,
    output logic [tcw_pkg::CELL_W-1:0]   ram_wdata,
    output logic [ADDR_W-1:0]            ram_raddr,
    input  logic [tcw_pkg::CELL_W-1:0]   ram_rdata,
    output logic                         empty,
    input  logic                         pop,
    output tcw_pkg::rsp_t                response
);
    import tcw_pkg::*;

    localparam int ROW_W = $clog2(ROWS);
    localparam int COL_W = $clog2(COLUMNS);
    localparam int RS_W  = ROW_W + 1;

    localparam logic [1:0] S_INIT = 2'd0;
    localparam logic [1:0] S_IDLE = 2'd1;
    localparam logic [1:0] S_FILL = 2'd2;
    localparam logic [1:0] S_READ = 2'd3;

    logic [1:0]        state_reg,     state_next;
    logic [ROW_W-1:0]  row_reg,       row_next;
    logic [COL_W-1:0]  col_reg,       col_next;
    logic [ROW_W-1:0]  top_reg,       top_next;
    logic [ADDR_W-1:0] fill_addr_reg, fill_addr_next;
    logic [ADDR_W-1:0] fill_end_reg,  fill_end_next;
    logic [CELL_W-1:0] fill_data_reg, fill_data_next;
    logic              out_valid_reg;
    rsp_t              out_data_reg;

    logic              slot_free;
    logic              start;
    logic              res_valid;
    logic [CELL_W-1:0] cell_value;
    logic              do_newline;
    logic [ROW_W-1:0]  addr_row;
    logic [COL_W-1:0]  addr_col;
    logic [RS_W-1:0]   row_sum;
    logic [ROW_W-1:0]  phys_row;
    logic [ADDR_W-1:0] cell_addr;
    logic [ADDR_W-1:0] scroll_base;
    logic [ROW_W-1:0]  top_inc;
    logic [CELL_W-1:0] blank;

    assign slot_free = !out_valid_reg || pop;
    assign start     = (state_reg == S_IDLE) && cmd_valid && slot_free;
    assign init_busy = (state_reg == S_INIT);
    assign empty     = !out_valid_reg;
    assign response  = out_data_reg;
    assign blank     = {text_color, CH_BLANK};

    always_comb
    begin
        addr_row = (cmd.op == OP_READ) ? ROW_W'(cmd.row) : row_reg;
        case (cmd.op)
            OP_READ:      addr_col = COL_W'(cmd.col);
            OP_BACKSPACE: addr_col = col_reg - 1'b1;
            default:      addr_col = col_reg;
        endcase
        row_sum  = {1'b0, addr_row} + {1'b0, top_reg};
        phys_row = (row_sum >= RS_W'(ROWS)) ? ROW_W'(row_sum - RS_W'(ROWS)) : ROW_W'(row_sum);
        cell_addr   = ADDR_W'(phys_row) * ADDR_W'(COLUMNS) + ADDR_W'(addr_col);
        scroll_base = ADDR_W'(top_reg) * ADDR_W'(COLUMNS);
        top_inc     = (top_reg == ROW_W'(ROWS - 1)) ? '0 : top_reg + 1'b1;
    end

    assign ram_raddr = cell_addr;

    always_comb
    begin
        state_next     = state_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        top_next       = top_reg;
        fill_addr_next = fill_addr_reg;
        fill_end_next  = fill_end_reg;
        fill_data_next = fill_data_reg;
        res_valid      = 1'b0;
        cell_value     = '0;
        do_newline     = 1'b0;
        cmd_pop        = 1'b0;
        ram_we         = 1'b0;
        ram_waddr      = fill_addr_reg;
        ram_wdata      = fill_data_reg;

        case (state_reg)
            S_INIT:
            begin
                ram_we = 1'b1;
                if (fill_addr_reg == fill_end_reg)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    fill_addr_next = fill_addr_reg + 1'b1;
                end
            end
            S_FILL:
            begin
                ram_we = 1'b1;
                if (fill_addr_reg == fill_end_reg)
                begin
                    state_next = S_IDLE;
                    res_valid  = 1'b1;
                end
                else
                begin
                    fill_addr_next = fill_addr_reg + 1'b1;
                end
            end
            S_READ:
            begin
                res_valid  = 1'b1;
                cell_value = ram_rdata;
                state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (start)
                begin
                    cmd_pop = 1'b1;
                    case (cmd.op)
                        OP_PUT:
                        begin
                            ram_we    = 1'b1;
                            ram_waddr = cell_addr;
                            ram_wdata = {text_color, cmd.ch};
                            if (col_reg == COL_W'(COLUMNS - 1))
                            begin
                                do_newline = 1'b1;
                            end
                            else
                            begin
                                col_next  = col_reg + 1'b1;
                                res_valid = 1'b1;
                            end
                        end
                        OP_NEWLINE:
                        begin
                            do_newline = 1'b1;
                        end
                        OP_BACKSPACE:
                        begin
                            if (col_reg != '0)
                            begin
                                ram_we    = 1'b1;
                                ram_waddr = cell_addr;
                                ram_wdata = blank;
                                col_next  = col_reg - 1'b1;
                            end
                            res_valid = 1'b1;
                        end
                        OP_READ:
                        begin
                            state_next = S_READ;
                        end
                        OP_CLEAR:
                        begin
                            fill_addr_next = '0;
                            fill_end_next  = ADDR_W'(CELLS - 1);
                            fill_data_next = blank;
                            top_next       = '0;
                            row_next       = '0;
                            col_next       = '0;
                            state_next     = S_FILL;
                        end
                        default:
                        begin
                            res_valid = 1'b1;
                        end
                    endcase
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (do_newline)
        begin
            col_next = '0;
            if (row_reg == ROW_W'(ROWS - 1))
            begin
                fill_addr_next = scroll_base;
                fill_end_next  = scroll_base + ADDR_W'(COLUMNS - 1);
                fill_data_next = blank;
                top_next       = top_inc;
                state_next     = S_FILL;
            end
            else
            begin
                row_next  = row_reg + 1'b1;
                res_valid = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            row_reg       <= '0;
            col_reg       <= '0;
            top_reg       <= '0;
            fill_addr_reg <= '0;
            fill_end_reg  <= ADDR_W'(CELLS - 1);
            fill_data_reg <= RESET_CELL;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            row_reg       <= row_next;
            col_reg       <= col_next;
            top_reg       <= top_next;
            fill_addr_reg <= fill_addr_next;
            fill_end_reg  <= fill_end_next;
            fill_data_reg <= fill_data_next;
            if (res_valid)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (pop)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            out_data_reg.cell_value <= cell_value;
            out_data_reg.cursor_row <= ROW_FIELD_W'(row_next);
            out_data_reg.cursor_col <= COL_FIELD_W'(col_next);
        end
    end

endmodule

/* dv/tcw_console_checker.sv */
// Checker that predicts the console response words and compares them with the block's output.
`timescale 1ns / 1ps
module tcw_console_checker #(
    parameter int ROWS    = tcw_pkg::DEFAULT_ROWS,
    parameter int COLUMNS = tcw_pkg::DEFAULT_COLUMNS
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    input  logic                        full,
    input  tcw_pkg::req_t               request,
    input  logic                        empty,
    input  logic                        pop,
    input  tcw_pkg::rsp_t               response,
    input  logic                        cfg_we,
    input  logic [tcw_pkg::COLOR_W-1:0] cfg_data,
    output int                          mismatches,
    output int                          awaiting
);
    import tcw_pkg::*;

    logic [CELL_W-1:0]  grid [ROWS][COLUMNS];
    int unsigned        cur_row;
    int unsigned        cur_col;
    logic [COLOR_W-1:0] color;
    rsp_t               awaited_rsp [$];

    function automatic void fill_grid(input logic [COLOR_W-1:0] c);
        for (int r = 0; r < ROWS; r++)
            for (int k = 0; k < COLUMNS; k++)
                grid[r][k] = {c, CH_BLANK};
    endfunction

    function automatic void line_feed();
        cur_col = 0;
        cur_row++;
        if (cur_row >= ROWS)
        begin
            for (int r = 0; r < ROWS - 1; r++)
                for (int k = 0; k < COLUMNS; k++)
                    grid[r][k] = grid[r+1][k];
            for (int k = 0; k < COLUMNS; k++)
                grid[ROWS-1][k] = {color, CH_BLANK};
            cur_row = ROWS - 1;
        end
    endfunction

    function automatic void put_char(input logic [CHAR_W-1:0] ch);
        if (ch == CH_NEWLINE)
        begin
            line_feed();
        end
        else if (ch == CH_BACKSPACE)
        begin
            if (cur_col > 0)
            begin
                cur_col--;
                grid[cur_row][cur_col] = {color, CH_BLANK};
            end
        end
        else
        begin
            grid[cur_row][cur_col] = {color, ch};
            cur_col++;
            if (cur_col >= COLUMNS)
                line_feed();
        end
    endfunction

    function automatic rsp_t apply_request(input req_t w);
        rsp_t r;
        r = '0;
        case (w.mode)
            MODE_PUT:
                put_char(w.char_code);
            MODE_READ:
                if (w.read_row < ROWS && w.read_col < COLUMNS)
                    r.cell_value = grid[w.read_row][w.read_col];
            MODE_CLEAR:
            begin
                fill_grid(color);
                cur_row = 0;
                cur_col = 0;
            end
            default:
                ;
        endcase
        r.cursor_row = cur_row[ROW_FIELD_W-1:0];
        r.cursor_col = cur_col[COL_FIELD_W-1:0];
        return r;
    endfunction

    function automatic void check_word(input rsp_t got);
        rsp_t want;
        if (awaited_rsp.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: response word with none awaited: cell %h row %0d col %0d",
                         $realtime, got.cell_value, got.cursor_row, got.cursor_col);
            return;
        end
        want = awaited_rsp.pop_front();
        if (got.cell_value != want.cell_value || got.cursor_row != want.cursor_row ||
            got.cursor_col != want.cursor_col)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: expected cell %h row %0d col %0d, got cell %h row %0d col %0d",
                         $realtime, want.cell_value, want.cursor_row, want.cursor_col,
                         got.cell_value, got.cursor_row, got.cursor_col);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            color = RESET_COLOR;
            fill_grid(RESET_COLOR);
            cur_row = 0;
            cur_col = 0;
            awaited_rsp.delete();
            mismatches = 0;
        end
        else
        begin
            if (pop && !empty)
                check_word(response);
            if (push && !full)
                awaited_rsp.push_back(apply_request(request));
            if (cfg_we)
                color = cfg_data;
        end
        awaiting = awaited_rsp.size();
    end

endmodule

/* dv/tb_text_console_writer.sv */
// Testbench top for the text console writer: stimulus, flow control and verdict.
`timescale 1ns / 1ps
module tb_text_console_writer;
    import tcw_pkg::*;

    localparam int ROWS          = DEFAULT_ROWS;
    localparam int COLUMNS       = DEFAULT_COLUMNS;
    localparam int SETTLE_CYCLES = ROWS * COLUMNS + 100;
    localparam int CYCLE_LIMIT   = 5000000;
    localparam int PHASE_WORDS   = 245;
    localparam int HOLD_CYCLES   = 400;

    localparam logic [MODE_W-1:0] MODE_NOP = 2'd3;

    logic               clk      = 1'b0;
    logic               rst_n    = 1'b0;
    logic               push     = 1'b0;
    logic               pop      = 1'b0;
    logic               cfg_we   = 1'b0;
    logic [COLOR_W-1:0] cfg_data = '0;
    req_t               request  = '0;
    logic               full;
    logic               empty;
    rsp_t               response;
    int                 mismatches;
    int                 awaiting;
    int                 send_gap    = 0;
    int                 recv_gap    = 0;
    int                 hold_asks   = 0;
    int                 holds_taken = 0;
    int                 hold_left   = 0;
    int                 cycles      = 0;

    text_console_writer #(
        .ROWS    (ROWS),
        .COLUMNS (COLUMNS)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .request  (request),
        .empty    (empty),
        .pop      (pop),
        .response (response),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data)
    );

    tcw_console_checker #(
        .ROWS    (ROWS),
        .COLUMNS (COLUMNS)
    ) checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .request    (request),
        .empty      (empty),
        .pop        (pop),
        .response   (response),
        .cfg_we     (cfg_we),
        .cfg_data   (cfg_data),
        .mismatches (mismatches),
        .awaiting   (awaiting)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // hold off the reader for a long stretch on request
    always @(negedge clk)
    begin
        if (holds_taken != hold_asks)
        begin
            holds_taken <= hold_asks;
            hold_left   <= HOLD_CYCLES;
            pop         <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            pop       <= 1'b0;
        end
        else
        begin
            pop <= ($urandom_range(99) >= recv_gap);
        end
    end

    function automatic req_t req_word(input logic [MODE_W-1:0]      m,
                                      input logic [CHAR_W-1:0]      ch,
                                      input logic [ROW_FIELD_W-1:0] r,
                                      input logic [COL_FIELD_W-1:0] c);
        req_t w;
        w.mode      = m;
        w.char_code = ch;
        w.read_row  = r;
        w.read_col  = c;
        return w;
    endfunction

    function automatic req_t random_word();
        req_t w;
        int   pick;
        w.read_row  = ROW_FIELD_W'($urandom_range(31));
        w.read_col  = COL_FIELD_W'($urandom_range(127));
        w.char_code = CHAR_W'($urandom_range(255));
        pick = $urandom_range(99);
        if (pick < 1)
        begin
            w.mode = MODE_CLEAR;
        end
        else if (pick < 2)
        begin
            w.mode = MODE_NOP;
        end
        else if (pick < 17)
        begin
            w.mode = MODE_READ;
            if ($urandom_range(3) != 0)
            begin
                w.read_row = ROW_FIELD_W'($urandom_range(ROWS - 1));
                w.read_col = COL_FIELD_W'($urandom_range(COLUMNS - 1));
            end
        end
        else
        begin
            w.mode = MODE_PUT;
            pick = $urandom_range(99);
            if (pick < 12)
                w.char_code = CH_NEWLINE;
            else if (pick < 20)
                w.char_code = CH_BACKSPACE;
            else if (pick < 85)
                w.char_code = CHAR_W'($urandom_range(8'h7E, 8'h20));
        end
        return w;
    endfunction

    task automatic send_word(input req_t w);
        while ($urandom_range(99) < send_gap)
        begin
            push <= 1'b0;
            @(negedge clk);
        end
        push    <= 1'b1;
        request <= w;
        @(posedge clk);
        while (full)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic drain();
        push <= 1'b0;
        @(posedge clk);
        while (awaiting != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic set_color(input logic [COLOR_W-1:0] c);
        drain();
        cfg_we   <= 1'b1;
        cfg_data <= c;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic run_phase(input int words);
        int n;
        int len;
        n = 0;
        while (n < words)
        begin
            if ($urandom_range(49) == 0)
            begin
                len = $urandom_range(COLUMNS + 6, COLUMNS - 4);
                for (int i = 0; i < len; i++)
                    send_word(req_word(MODE_PUT, CHAR_W'($urandom_range(8'h7E, 8'h20)),
                                       ROW_FIELD_W'($urandom_range(31)),
                                       COL_FIELD_W'($urandom_range(127))));
                n += len;
            end
            else
            begin
                send_word(random_word());
                n++;
            end
        end
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        while (full)
            @(posedge clk);
        @(negedge clk);

        send_word(req_word(MODE_READ, '0, '0, '0));
        send_word(req_word(MODE_READ, '0, ROW_FIELD_W'(ROWS - 1), COL_FIELD_W'(COLUMNS - 1)));
        send_word(req_word(MODE_READ, '0, ROW_FIELD_W'(ROWS), '0));
        send_word(req_word(MODE_READ, '1, '1, '1));
        send_word(req_word(MODE_READ, '0, '0, COL_FIELD_W'(COLUMNS)));
        send_word(req_word(MODE_PUT, 8'h41, '0, '0));
        send_word(req_word(MODE_PUT, 8'h00, '0, '0));
        send_word(req_word(MODE_PUT, 8'hFF, '1, '1));
        send_word(req_word(MODE_PUT, CH_BACKSPACE, '0, '0));
        send_word(req_word(MODE_READ, '0, '0, COL_FIELD_W'(2)));
        send_word(req_word(MODE_READ, '0, '0, COL_FIELD_W'(1)));
        send_word(req_word(MODE_PUT, CH_NEWLINE, '0, '0));
        send_word(req_word(MODE_PUT, CH_BACKSPACE, '1, '1));
        send_word(req_word(MODE_NOP, '1, '1, '1));
        send_word(req_word(MODE_READ, '0, '0, '0));
        send_word(req_word(MODE_CLEAR, '1, '1, '1));
        send_word(req_word(MODE_READ, '0, '0, '0));
        send_word(req_word(MODE_PUT, 8'h5A, '1, '1));

        set_color(8'hFF);
        send_gap = 19;
        recv_gap = 80;
        run_phase(PHASE_WORDS);

        set_color(8'h00);
        send_gap = 80;
        recv_gap = 19;
        run_phase(PHASE_WORDS / 2);
        push <= 1'b0;
        @(posedge clk);
        while (awaiting != 0)
            @(posedge clk);
        @(negedge clk);
        run_phase(PHASE_WORDS / 2);

        set_color(COLOR_W'($urandom_range(255)));
        send_gap = 0;
        recv_gap = 0;
        hold_asks++;
        run_phase(PHASE_WORDS);

        drain();
        if (mismatches == 0 && awaiting == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

/* sim.f */
src/tcw_pkg.sv
src/tcw_ram.sv
src/tcw_front.sv
src/tcw_back.sv
src/text_console_writer.sv
dv/tcw_console_checker.sv
dv/tb_text_console_writer.sv
